[src/tsps_pkg.sv]
// ----------------------------------------------------------------------------
// tsps_pkg
// Types, codes and request byte tables for the telemetry poll sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tsps_pkg;

   // input operation codes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_BYTE = 1'b1;

   // result kinds
   localparam logic [2:0] KIND_SEND    = 3'd0;
   localparam logic [2:0] KIND_FRAME   = 3'd1;
   localparam logic [2:0] KIND_DONE    = 3'd2;
   localparam logic [2:0] KIND_TIMEOUT = 3'd3;
   localparam logic [2:0] KIND_CONSOLE = 3'd4;
   localparam logic [2:0] KIND_SPEED   = 3'd5;

   // phase codes: idle, then request (odd) and wait (even) per sensor
   localparam logic [3:0] PH_IDLE    = 4'd0;
   localparam logic [3:0] PH_GPS_REQ = 4'd1;
   localparam logic [3:0] PH_LAST    = 4'd8;

   // register indexes
   localparam logic [2:0] REG_WAIT_TICKS = 3'd0;
   localparam logic [2:0] REG_STARTUP    = 3'd1;
   localparam logic [2:0] REG_GPS_LEN    = 3'd2;
   localparam logic [2:0] REG_EAM_LEN    = 3'd3;
   localparam logic [2:0] REG_GAM_LEN    = 3'd4;
   localparam logic [2:0] REG_RX_LEN     = 3'd5;

   localparam logic [3:0] REQ_LAST_POS = 4'd8;

   localparam logic [7:0] LF = 8'h0A;
   localparam logic [7:0] CR = 8'h0D;

   typedef struct packed {
      logic [15:0] wait_ticks;
      logic [15:0] startup_window;
      logic [7:0]  gps_frame_len;
      logic [7:0]  eam_frame_len;
      logic [7:0]  gam_frame_len;
      logic [7:0]  rx_frame_len;
   } cfg_type;

   // compact description of the results one item causes
   typedef struct packed {
      logic        burst;      // nine request bytes for sensor
      logic        with_done;  // frame byte followed by frame done
      logic [2:0]  kind;
      logic [7:0]  data_byte;
      logic [7:0]  byte_index;
      logic [1:0]  sensor;
      logic [15:0] tally;
   } desc_type;

   typedef struct packed {
      logic [1:0] count;
   } q_stat_type;

   function automatic logic [7:0] req_byte(input logic [1:0] s, input logic [3:0] pos);
      logic [7:0] b;
      b = 8'h00;
      unique case (pos)
         4'd0: b = 8'h00;
         4'd1: b = 8'h03;
         4'd2: b = 8'hFC;
         4'd3: b = 8'h00;
         4'd4: b = 8'h00;
         4'd5: b = 8'h04;
         4'd6: begin
            unique case (s)
               2'd0: b = 8'h38;
               2'd1: b = 8'h36;
               2'd2: b = 8'h35;
               default: b = 8'h34;
            endcase
         end
         4'd7: begin
            unique case (s)
               2'd0: b = 8'h9F;
               2'd1: b = 8'h51;
               2'd2: b = 8'h32;
               default: b = 8'h13;
            endcase
         end
         4'd8: begin
            unique case (s)
               2'd0: b = 8'h7B;
               2'd1: b = 8'h9A;
               2'd2: b = 8'hAA;
               default: b = 8'hBA;
            endcase
         end
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

[src/telemetry_sensor_poll_sequencer.sv]
// ----------------------------------------------------------------------------
// telemetry_sensor_poll_sequencer
// Polling master for a four-sensor telemetry link.
//
// Usage:
//   req_* carries one event per item: tuser = operation (0 tick, 1 byte),
//   tdata = received byte. rsp_* carries result items: tuser = kind,
//   tdata = data byte, byte index, sensor, tally; tlast marks the final
//   result that one input item causes. csr_* is an APB-style port holding
//   wait_ticks, startup_window and the four frame lengths.
//   State, counters and tallies update at the accepting edge and a result
//   descriptor enters a two-entry queue, which registers it before its first
//   result shows on rsp_*. While rsp_tready is high, results leave at one per
//   cycle, so an item that sends a request occupies the result port for its
//   nine request bytes, and items causing at most one result flow at one per
//   cycle. req_tready drops only when the queue holds two pending descriptors.
//   Items that cause no result need no queue slot.
//   A stalled receiver holds the current result steady; the queue keeps
//   taking items until it is full. Reset loads the register defaults,
//   returns to idle, clears counters and tallies and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module telemetry_sensor_poll_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic        req_tuser,   // [0] operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] data_byte, [15:8] byte_index, [17:16] sensor, [33:18] tally, pad
   output logic [39:0]      rsp_tdata,
   output logic [2:0]       rsp_tuser,   // [2:0] kind
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import tsps_pkg::*;

   cfg_type    cfg;
   desc_type   desc;
   q_stat_type q_stat;
   logic       accept;
   logic       push;
   logic [7:0]  out_data;
   logic [7:0]  out_index;
   logic [1:0]  out_sensor;
   logic [15:0] out_tally;

   // take items while a queue slot is free
   assign req_tready = q_stat.count != 2'd2;
   assign accept     = req_tvalid && req_tready;

   tsps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tsps_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .operation (req_tuser),
      .rx_byte   (req_tdata),
      .cfg       (cfg),
      .push      (push),
      .desc      (desc)
   );

   tsps_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .desc       (desc),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tlast  (rsp_tlast),
      .out_kind   (rsp_tuser),
      .out_data   (out_data),
      .out_index  (out_index),
      .out_sensor (out_sensor),
      .out_tally  (out_tally),
      .stat       (q_stat)
   );

   // pack result fields, lowest field first
   assign rsp_tdata = {6'b000000, out_tally, out_sensor, out_index, out_data};

   // a descriptor only enters on an accepted item
   a_push_on_accept : assert property (@(posedge clock) disable iff (reset)
      push |-> accept)
      else $error("descriptor pushed without an accepted item");

   // queue is empty right after reset
   a_empty_after_reset : assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // draining the only descriptor with nothing new leaves the port idle
   a_drain_idle : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast && q_stat.count == 2'd1 && !push)
      |=> !rsp_tvalid)
      else $error("result valid after queue drained");

   // a full queue must hold off the input side
   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      (q_stat.count == 2'd2) |-> !accept)
      else $error("item accepted while queue full");

endmodule

`default_nettype wire

[src/tsps_csr.sv]
// ----------------------------------------------------------------------------
// tsps_csr
// APB-style register file holding the sequencer configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module tsps_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [4:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output tsps_pkg::cfg_type     cfg
);
   import tsps_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_WAIT_TICKS: cfg_in.wait_ticks     = csr_pwdata[15:0];
            REG_STARTUP:    cfg_in.startup_window = csr_pwdata[15:0];
            REG_GPS_LEN:    cfg_in.gps_frame_len  = csr_pwdata[7:0];
            REG_EAM_LEN:    cfg_in.eam_frame_len  = csr_pwdata[7:0];
            REG_GAM_LEN:    cfg_in.gam_frame_len  = csr_pwdata[7:0];
            REG_RX_LEN:     cfg_in.rx_frame_len   = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_WAIT_TICKS: csr_prdata = {16'h0000, cfg_ff.wait_ticks};
         REG_STARTUP:    csr_prdata = {16'h0000, cfg_ff.startup_window};
         REG_GPS_LEN:    csr_prdata = {24'h000000, cfg_ff.gps_frame_len};
         REG_EAM_LEN:    csr_prdata = {24'h000000, cfg_ff.eam_frame_len};
         REG_GAM_LEN:    csr_prdata = {24'h000000, cfg_ff.gam_frame_len};
         REG_RX_LEN:     csr_prdata = {24'h000000, cfg_ff.rx_frame_len};
         default:        csr_prdata = 32'h0000_0000;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wait_ticks     <= 16'd100;
         cfg_ff.startup_window <= 16'd20000;
         cfg_ff.gps_frame_len  <= 8'd51;
         cfg_ff.eam_frame_len  <= 8'd63;
         cfg_ff.gam_frame_len  <= 8'd57;
         cfg_ff.rx_frame_len   <= 8'd20;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[src/tsps_core.sv]
// ----------------------------------------------------------------------------
// tsps_core
// Poll state, counters and tallies; turns each accepted item that causes
// results into a result descriptor in one pass.
// ----------------------------------------------------------------------------
`default_nettype none

module tsps_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic              operation,
   input  wire logic [7:0]        rx_byte,
   input  wire tsps_pkg::cfg_type cfg,
   output logic                   push,
   output tsps_pkg::desc_type     desc
);
   import tsps_pkg::*;

   logic [3:0]  phase_ff, phase_in;
   logic [15:0] since_ff, since_in;
   logic [15:0] uptime_ff, uptime_in;
   logic [7:0]  bytes_ff, bytes_in;
   logic [7:0]  nl_run_ff, nl_run_in;
   logic [15:0] ok_ff [4];
   logic [15:0] ok_in [4];
   logic [15:0] fail_ff [4];
   logic [15:0] fail_in [4];

   logic        active;
   logic        waiting;
   logic [1:0]  s;
   logic [3:0]  ph_minus;
   logic [15:0] since_nx;
   logic [15:0] uptime_nx;
   logic [7:0]  bytes_nx;
   logic [7:0]  nl_nx;
   logic [7:0]  frame_len;
   logic [15:0] ok_nx;
   logic [15:0] fail_nx;
   logic [3:0]  next_ph;
   logic        expired;

   assign active   = (phase_ff >= PH_GPS_REQ) && (phase_ff <= PH_LAST);
   assign ph_minus = phase_ff - 4'd1;
   assign s        = active ? ph_minus[2:1] : 2'd0;
   assign waiting  = active && !phase_ff[0];

   // saturating tick counters
   assign uptime_nx = (operation == OP_TICK && uptime_ff != 16'hFFFF) ?
                      uptime_ff + 16'd1 : uptime_ff;
   assign since_nx  = (operation == OP_TICK && since_ff != 16'hFFFF) ?
                      since_ff + 16'd1 : since_ff;
   assign expired   = since_nx > cfg.wait_ticks;

   assign bytes_nx = bytes_ff + 8'd1;
   assign nl_nx    = (rx_byte == LF || rx_byte == CR) ? nl_run_ff + 8'd1 : 8'd0;
   assign ok_nx    = ok_ff[s] + 16'd1;
   assign fail_nx  = fail_ff[s] + 16'd1;
   assign next_ph  = (s == 2'd3) ? PH_IDLE : {1'b0, s, 1'b0} + 4'd3;

   always_comb begin
      unique case (s)
         2'd0: frame_len = cfg.gps_frame_len;
         2'd1: frame_len = cfg.eam_frame_len;
         2'd2: frame_len = cfg.gam_frame_len;
         default: frame_len = cfg.rx_frame_len;
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      since_in  = since_ff;
      uptime_in = uptime_ff;
      bytes_in  = bytes_ff;
      nl_run_in = nl_run_ff;
      for (int i = 0; i < 4; i++) begin
         ok_in[i]   = ok_ff[i];
         fail_in[i] = fail_ff[i];
      end
      push = 1'b0;
      desc = '0;
      desc.sensor = s;

      if (accept) begin
         uptime_in = uptime_nx;
         since_in  = since_nx;
         if (!active) begin
            desc.sensor = 2'd0;
            if (uptime_nx >= cfg.startup_window) begin
               push      = 1'b1;
               desc.kind = KIND_SPEED;
               phase_in  = PH_GPS_REQ;
            end else if (operation == OP_BYTE) begin
               nl_run_in = nl_nx;
               if (nl_nx == 8'd3) begin
                  push      = 1'b1;
                  desc.kind = KIND_CONSOLE;
               end
            end
         end else if (!waiting) begin
            if (operation == OP_TICK && expired) begin
               since_in   = 16'd0;
               bytes_in   = 8'd0;
               push       = 1'b1;
               desc.burst = 1'b1;
               desc.kind  = KIND_SEND;
               phase_in   = phase_ff + 4'd1;
            end
         end else if (operation == OP_BYTE) begin
            push            = 1'b1;
            desc.kind       = KIND_FRAME;
            desc.data_byte  = rx_byte;
            desc.byte_index = bytes_ff;
            bytes_in        = bytes_nx;
            if (bytes_nx == frame_len) begin
               ok_in[s]       = ok_nx;
               desc.with_done = 1'b1;
               desc.tally     = ok_nx;
               phase_in       = next_ph;
            end
         end else if (expired) begin
            fail_in[s] = fail_nx;
            push       = 1'b1;
            desc.kind  = KIND_TIMEOUT;
            desc.tally = fail_nx;
            phase_in   = next_ph;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         since_ff  <= 16'd0;
         uptime_ff <= 16'd0;
         bytes_ff  <= 8'd0;
         nl_run_ff <= 8'd0;
         for (int i = 0; i < 4; i++) begin
            ok_ff[i]   <= 16'd0;
            fail_ff[i] <= 16'd0;
         end
      end else begin
         phase_ff  <= phase_in;
         since_ff  <= since_in;
         uptime_ff <= uptime_in;
         bytes_ff  <= bytes_in;
         nl_run_ff <= nl_run_in;
         for (int i = 0; i < 4; i++) begin
            ok_ff[i]   <= ok_in[i];
            fail_ff[i] <= fail_in[i];
         end
      end
   end

endmodule

`default_nettype wire

[src/tsps_outq.sv]
// ----------------------------------------------------------------------------
// tsps_outq
// Two-entry descriptor queue and result emitter, one result per cycle while rsp_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module tsps_outq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire tsps_pkg::desc_type desc,
   input  wire logic               rsp_tready,
   output logic                    rsp_tvalid,
   output logic                    rsp_tlast,
   output logic [2:0]              out_kind,
   output logic [7:0]              out_data,
   output logic [7:0]              out_index,
   output logic [1:0]              out_sensor,
   output logic [15:0]             out_tally,
   output tsps_pkg::q_stat_type    stat
);
   import tsps_pkg::*;

   desc_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic [3:0] pos_ff, pos_in;

   desc_type   head;
   logic       fire;
   logic       pop;
   logic       is_last;
   logic       done_slot;

   assign head      = entry_ff[rd_ptr_ff];
   assign rsp_tvalid = count_ff != 2'd0;
   assign done_slot = head.with_done && pos_ff[0];

   always_comb begin
      if (head.burst) begin
         is_last = pos_ff == REQ_LAST_POS;
      end else if (head.with_done) begin
         is_last = pos_ff[0];
      end else begin
         is_last = 1'b1;
      end
   end

   assign fire = rsp_tvalid && rsp_tready;
   assign pop  = fire && is_last;

   always_comb begin
      out_kind   = head.kind;
      out_data   = head.data_byte;
      out_index  = head.byte_index;
      out_sensor = head.sensor;
      out_tally  = head.tally;
      if (head.burst) begin
         out_data = req_byte(head.sensor, pos_ff);
      end else if (done_slot) begin
         out_kind  = KIND_DONE;
         out_data  = 8'd0;
         out_index = 8'd0;
      end else if (head.with_done) begin
         out_tally = 16'd0;
      end
   end

   assign rsp_tlast = is_last;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      if (pop) begin
         pos_in = 4'd0;
      end else if (fire) begin
         pos_in = pos_ff + 4'd1;
      end else begin
         pos_in = pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         pos_ff    <= 4'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         pos_ff    <= pos_in;
      end
   end

   assign stat.count = count_ff;

endmodule

`default_nettype wire
